// File: rtl/bic_pkg.sv
// Shared types, constants and fixed-point helpers for the Butterworth IIR cascade.
// No dependencies; every other file of the block uses this package.
package bic_pkg;

  localparam int MAX_SECTIONS_DEF = 4;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS        = 20;
  localparam int COEF_W           = 24;
  localparam int DLY_W            = 40;
  localparam int ACC_W            = 48;
  localparam int PROD_W           = 64;
  localparam int RND_W            = PROD_W - FRAC_BITS;
  localparam int CFG_IDX_W        = 2;
  localparam int SEC_IDX_W        = 2;
  localparam int SEL_W            = 3;
  localparam int OP_W             = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 2'd0,
    REG_COUNT      = 2'd1,
    REG_STOP_OUTER = 2'd2,
    REG_STOP_MID   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_BAND = 2'd2,
    MODE_STOP = 2'd3
  } filt_mode_e;

  localparam logic [SEL_W-1:0] SEL_GAIN = 3'd0;
  localparam logic [SEL_W-1:0] SEL_MAX  = 3'd4;

  // multiply steps of one section
  localparam logic [OP_W-1:0] OP_FB1   = 3'd0;
  localparam logic [OP_W-1:0] OP_FB2   = 3'd1;
  localparam logic [OP_W-1:0] OP_FB3   = 3'd2;
  localparam logic [OP_W-1:0] OP_FB4   = 3'd3;
  localparam logic [OP_W-1:0] OP_SO1   = 3'd4;
  localparam logic [OP_W-1:0] OP_SMID  = 3'd5;
  localparam logic [OP_W-1:0] OP_SO3   = 3'd6;
  localparam logic [OP_W-1:0] OP_GAIN  = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_NUM  = 5'b01000,
    ST_NSAT = 5'b10000
  } cell_state_e;

  typedef struct packed {
    filt_mode_e               mode;
    logic signed [COEF_W-1:0] stop_outer;
    logic signed [COEF_W-1:0] stop_mid;
  } cell_cfg_t;

  typedef struct packed {
    logic                     en;
    logic [SEC_IDX_W-1:0]     section;
    logic [SEL_W-1:0]         sel;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

  typedef struct packed {
    logic                    valid;
    logic signed [DLY_W-1:0] x;
  } link_t;

  function automatic logic signed [ACC_W-1:0] ext_dly(input logic signed [DLY_W-1:0] v);
    return {{(ACC_W-DLY_W){v[DLY_W-1]}}, v};
  endfunction

  function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< (DLY_W - 1)) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[DLY_W-1:0];
    else if (v < lo) return lo[DLY_W-1:0];
    else return v[DLY_W-1:0];
  endfunction

endpackage

// File: rtl/bic_in_if.sv
// Input channel of the IIR cascade: valid/ready plus one command item.
// Depends on bic_pkg for field widths.
interface bic_in_if #(parameter int SAMPLE_WIDTH = bic_pkg::SAMPLE_WIDTH_DEF);
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic signed [SAMPLE_WIDTH-1:0]        sample_in;
  logic [bic_pkg::SEC_IDX_W-1:0]         section_index;
  logic [bic_pkg::SEL_W-1:0]             coef_select;
  logic signed [bic_pkg::COEF_W-1:0]     coef_value;

  modport source (output valid, cmd, sample_in, section_index, coef_select, coef_value,
                  input ready);
  modport sink   (input valid, cmd, sample_in, section_index, coef_select, coef_value,
                  output ready);
endinterface

// File: rtl/bic_out_if.sv
// Result channel of the IIR cascade: valid/ready plus filtered sample and clip flag.
// No package dependency beyond the sample width parameter.
interface bic_out_if #(parameter int SAMPLE_WIDTH = bic_pkg::SAMPLE_WIDTH_DEF);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

// File: rtl/bic_cell.sv
// One filter section of the cascade: coefficients, delays and a shared multiplier.
// Depends on bic_pkg.
module bic_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               active_i,
  input  bic_pkg::cell_cfg_t cfg_i,
  input  bic_pkg::coef_wr_t  cw_i,
  input  bic_pkg::link_t     x_i,
  output bic_pkg::link_t     y_o
);
  import bic_pkg::*;

  cell_state_e              st_q, st_d;
  logic [OP_W-1:0]          op_q, op_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DLY_W-1:0]  w0_q, w0_d;
  logic signed [DLY_W-1:0]  num_q, num_d;
  logic signed [DLY_W-1:0]  dly_q [4];
  logic signed [DLY_W-1:0]  dly_d [4];
  logic signed [COEF_W-1:0] coef_q [5];
  logic                     yv_q, yv_d;
  logic signed [DLY_W-1:0]  y_q, y_d;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [DLY_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] rsum;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  w0_sat;
  logic signed [ACC_W-1:0]  base;
  logic                     fourth;
  logic                     stop;

  assign fourth = cfg_i.mode[1];
  assign stop   = (cfg_i.mode == MODE_STOP);

  always_comb begin
    unique case (op_q)
      OP_FB1:  begin mul_a = coef_q[1];        mul_b = dly_q[0]; end
      OP_FB2:  begin mul_a = coef_q[2];        mul_b = dly_q[1]; end
      OP_FB3:  begin mul_a = coef_q[3];        mul_b = dly_q[2]; end
      OP_FB4:  begin mul_a = coef_q[4];        mul_b = dly_q[3]; end
      OP_SO1:  begin mul_a = cfg_i.stop_outer; mul_b = dly_q[0]; end
      OP_SMID: begin mul_a = cfg_i.stop_mid;   mul_b = dly_q[1]; end
      OP_SO3:  begin mul_a = cfg_i.stop_outer; mul_b = dly_q[2]; end
      OP_GAIN: begin mul_a = coef_q[0];        mul_b = num_q;    end
    endcase
  end

  // round half up to Q27.20
  assign rsum = prod_q + (PROD_W'(1) <<< (FRAC_BITS - 1));
  assign rnd  = {{(ACC_W-RND_W){rsum[PROD_W-1]}}, rsum[PROD_W-1:FRAC_BITS]};
  assign w0_sat = ext_dly(sat_dly(acc_q));

  always_comb begin
    unique case (cfg_i.mode)
      MODE_LOW:  base = w0_sat + (ext_dly(dly_q[0]) <<< 1) + ext_dly(dly_q[1]);
      MODE_HIGH: base = w0_sat - (ext_dly(dly_q[0]) <<< 1) + ext_dly(dly_q[1]);
      MODE_BAND: base = w0_sat - (ext_dly(dly_q[1]) <<< 1) + ext_dly(dly_q[3]);
      MODE_STOP: base = w0_sat + ext_dly(dly_q[3]);
    endcase
  end

  always_comb begin
    st_d   = st_q;
    op_d   = op_q;
    acc_d  = acc_q;
    prod_d = prod_q;
    w0_d   = w0_q;
    num_d  = num_q;
    dly_d  = dly_q;
    yv_d   = 1'b0;
    y_d    = y_q;
    unique case (st_q)
      ST_IDLE: begin
        if (x_i.valid) begin
          if (active_i) begin
            acc_d = ext_dly(x_i.x);
            op_d  = OP_FB1;
            st_d  = ST_MUL;
          end else begin
            // pass through an unused section
            y_d  = x_i.x;
            yv_d = 1'b1;
          end
        end
      end
      ST_MUL: begin
        prod_d = mul_a * mul_b;
        st_d   = ST_ACC;
      end
      ST_ACC: begin
        if (op_q == OP_GAIN) begin
          y_d      = sat_dly(rnd);
          yv_d     = 1'b1;
          dly_d[0] = w0_q;
          dly_d[1] = dly_q[0];
          if (fourth) begin
            dly_d[2] = dly_q[1];
            dly_d[3] = dly_q[2];
          end
          st_d = ST_IDLE;
        end else begin
          if (op_q == OP_SO1 || op_q == OP_SO3) acc_d = acc_q - rnd;
          else acc_d = acc_q + rnd;
          if ((op_q == OP_FB2 && !fourth) || op_q == OP_FB4) begin
            st_d = ST_NUM;
          end else if (op_q == OP_SO3) begin
            st_d = ST_NSAT;
          end else begin
            op_d = op_q + OP_W'(1);
            st_d = ST_MUL;
          end
        end
      end
      ST_NUM: begin
        w0_d  = sat_dly(acc_q);
        acc_d = base;
        if (stop) begin
          op_d = OP_SO1;
          st_d = ST_MUL;
        end else begin
          st_d = ST_NSAT;
        end
      end
      ST_NSAT: begin
        num_d = sat_dly(acc_q);
        op_d  = OP_GAIN;
        st_d  = ST_MUL;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      op_q <= OP_FB1;
      yv_q <= 1'b0;
      for (int k = 0; k < 4; k++) dly_q[k] <= '0;
    end else begin
      st_q  <= st_d;
      op_q  <= op_d;
      yv_q  <= yv_d;
      dly_q <= dly_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    w0_q   <= w0_d;
    num_q  <= num_d;
    y_q    <= y_d;
  end

  always_ff @(posedge clk_i) begin
    if (cw_i.en && (32'(cw_i.section) == INDEX)) begin
      unique case (cw_i.sel)
        3'd0: coef_q[0] <= cw_i.value;
        3'd1: coef_q[1] <= cw_i.value;
        3'd2: coef_q[2] <= cw_i.value;
        3'd3: coef_q[3] <= cw_i.value;
        3'd4: coef_q[4] <= cw_i.value;
        default: ;
      endcase
    end
  end

  assign y_o.valid = yv_q;
  assign y_o.x     = y_q;

endmodule

// File: rtl/butterworth_iir_cascade_unit.sv
// Top level of the Butterworth IIR cascade: registers, cell chain, output stage.
// Depends on bic_pkg, bic_in_if, bic_out_if and bic_cell.
//
//  channel | dir | handshake     | carries
//  --------+-----+---------------+-------------------------------------------------
//  in_i    | in  | valid / ready | cmd, sample_in, section_index, coef_select, value
//  out_o   | out | valid / ready | sample_out, saturated
//  cfg     | in  | cfg_we_i      | cfg_idx_i, cfg_wdata_i (no stall)
//
// A coefficient write gives no result. A sample walks the chain of
// MAX_SECTIONS cells one after another; each cell runs its own 24x40
// multiplier over 3 to 8 products, each in a multiply state and an
// accumulate state, plus idle, numerator and numerator-saturate
// bookkeeping states. An unused section passes the sample on through
// its output register.
// One sample is in flight at a time; in_i.ready is low until its result has
// moved into the output register, which may still wait on out_o.ready.
// Reset clears delays and control; coefficients hold garbage until written.
module butterworth_iir_cascade_unit #(
  parameter int MAX_SECTIONS = bic_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_WIDTH = bic_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bic_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bic_pkg::COEF_W-1:0]          cfg_wdata_i,
  bic_in_if.sink                              in_i,
  bic_out_if.source                           out_o
);
  import bic_pkg::*;

  // configuration registers
  filt_mode_e               mode_q;
  logic [2:0]               count_q;
  logic signed [COEF_W-1:0] souter_q;
  logic signed [COEF_W-1:0] smid_q;

  logic                     busy_q;
  logic                     pend_q;
  logic signed [DLY_W-1:0]  fin_q;
  logic                     ov_q;
  logic signed [SAMPLE_WIDTH-1:0] so_q;
  logic                     sat_q;

  logic                     in_xfer;
  logic                     out_free;
  cell_cfg_t                cell_cfg;
  coef_wr_t                 cw;
  link_t                    link [MAX_SECTIONS+1];
  logic [MAX_SECTIONS-1:0]  link_v;

  logic signed [ACC_W-1:0]  samp_ext;
  logic signed [ACC_W-1:0]  fsum;
  logic signed [ACC_W-1:0]  fq;
  logic signed [ACC_W-1:0]  out_hi;
  logic signed [ACC_W-1:0]  out_lo;
  logic signed [SAMPLE_WIDTH-1:0] so_d;
  logic                     sat_d;

  assign in_i.ready = !busy_q;
  assign in_xfer    = in_i.valid && !busy_q;
  assign out_free   = !ov_q || out_o.ready;

  // register writes; every two-bit index names one of the four registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LOW;
      count_q  <= 3'd1;
      souter_q <= '0;
      smid_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MODE:       mode_q   <= filt_mode_e'(cfg_wdata_i[1:0]);
        REG_COUNT:      count_q  <= cfg_wdata_i[2:0];
        REG_STOP_OUTER: souter_q <= cfg_wdata_i;
        REG_STOP_MID:   smid_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cell_cfg.mode       = mode_q;
  assign cell_cfg.stop_outer = souter_q;
  assign cell_cfg.stop_mid   = smid_q;

  // coefficient write items drop out here when coef_select is out of range
  assign cw.en      = in_xfer && in_i.cmd && (in_i.coef_select <= SEL_MAX);
  assign cw.section = in_i.section_index;
  assign cw.sel     = in_i.coef_select;
  assign cw.value   = in_i.coef_value;

  // sample enters as sample * 2^20, clipped to the delay width
  assign samp_ext      = {{(ACC_W-SAMPLE_WIDTH){in_i.sample_in[SAMPLE_WIDTH-1]}},
                          in_i.sample_in} <<< FRAC_BITS;
  assign link[0].valid = in_xfer && !in_i.cmd;
  assign link[0].x     = sat_dly(samp_ext);

  for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
    logic act;
    assign act = (32'(count_q) > g);
    bic_cell #(.INDEX(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (act),
      .cfg_i    (cell_cfg),
      .cw_i     (cw),
      .x_i      (link[g]),
      .y_o      (link[g+1])
    );
    assign link_v[g] = link[g+1].valid;
  end

  // final rounding to an integer and clip to the sample width
  assign fsum   = ext_dly(fin_q) + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign fq     = fsum >>> FRAC_BITS;
  assign out_hi = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  assign out_lo = -out_hi - ACC_W'(1);

  always_comb begin
    if (fq > out_hi) begin
      so_d  = out_hi[SAMPLE_WIDTH-1:0];
      sat_d = 1'b1;
    end else if (fq < out_lo) begin
      so_d  = out_lo[SAMPLE_WIDTH-1:0];
      sat_d = 1'b1;
    end else begin
      so_d  = fq[SAMPLE_WIDTH-1:0];
      sat_d = 1'b0;
    end
  end

  // hold the chain result until the output register frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (link[0].valid) busy_q <= 1'b1;
      if (link[MAX_SECTIONS].valid) pend_q <= 1'b1;
      if (pend_q && out_free) begin
        pend_q <= 1'b0;
        busy_q <= 1'b0;
        ov_q   <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (link[MAX_SECTIONS].valid) fin_q <= link[MAX_SECTIONS].x;
    if (pend_q && out_free) begin
      so_q  <= so_d;
      sat_q <= sat_d;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.sample_out = so_q;
  assign out_o.saturated  = sat_q;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(link_v))
    else $error("more than one section output at once");
  a_chain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_v != '0) |-> busy_q)
    else $error("section output while no sample in flight");
  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> busy_q)
    else $error("pending result without a sample in flight");
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[0].valid |=> busy_q && !in_i.ready)
    else $error("sample accepted but block not busy");
`endif

endmodule

// File: tb/sv/butterworth_iir_cascade_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of butterworth_iir_cascade_unit: random and directed
// command items against a fixed-point predictor of the filter cascade.
// Depends on bic_pkg, bic_in_if, bic_out_if and butterworth_iir_cascade_unit from the RTL.
module butterworth_iir_cascade_unit_tb;
  import bic_pkg::*;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEF   = 1'b1;
  localparam int   N_SEC      = MAX_SECTIONS_DEF;
  localparam int   DRAIN_WAIT = 120;
  localparam int   STALL_LIM  = 4000;  // cycles with no transfer at all
  localparam int   HOLD_LEN   = 300;

  // Tracks filter state and holds the results still to come out of the block.
  class iir_scoreboard;
    typedef struct {
      logic signed [15:0] smp;
      logic               clip;
    } filt_out_t;

    longint     coef [N_SEC*5];
    longint     dly  [N_SEC*4];
    filt_mode_e mode;
    int         sec_cnt;
    longint     outer_g;
    longint     mid_g;
    filt_out_t  pending_q[$];
    int         errors;
    int         results;
    int         clips;
    int         coef_wr;

    function new();
      foreach (coef[i]) coef[i] = 0;
      foreach (dly[i]) dly[i] = 0;
      mode    = MODE_LOW;
      sec_cnt = 1;
      outer_g = 0;
      mid_g   = 0;
      errors  = 0;
      results = 0;
      clips   = 0;
      coef_wr = 0;
    endfunction

    function longint sat40(longint v);
      longint hi;
      hi = (64'sd1 <<< 39) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // Q3.20 times Q19.20, round half up back to Q19.20
    function longint mulq(longint c, longint w);
      return (c * w + (64'sd1 <<< 19)) >>> 20;
    endfunction

    function void set_reg(reg_idx_e idx, logic [COEF_W-1:0] v);
      case (idx)
        REG_MODE:       mode    = filt_mode_e'(v[1:0]);
        REG_COUNT:      sec_cnt = v[2:0];
        REG_STOP_OUTER: outer_g = longint'($signed(v));
        default:        mid_g   = longint'($signed(v));
      endcase
    endfunction

    function void note_item(logic cmd, logic signed [15:0] smp, logic [1:0] sec,
                            logic [2:0] sel, logic signed [COEF_W-1:0] val);
      longint    x, w0, w1, w2, w3, w4, fb, num, y;
      int        n;
      bit        fourth;
      filt_out_t e;
      if (cmd == CMD_COEF) begin
        // selects above the last feedback term are dropped by the block
        if (sel <= SEL_MAX) begin
          coef[sec*5 + sel] = val;
          coef_wr++;
        end
        return;
      end
      x      = smp;
      x      = x <<< 20;
      n      = (sec_cnt > N_SEC) ? N_SEC : sec_cnt;
      fourth = (mode == MODE_BAND) || (mode == MODE_STOP);
      for (int i = 0; i < n; i++) begin
        w1 = dly[4*i]; w2 = dly[4*i+1]; w3 = dly[4*i+2]; w4 = dly[4*i+3];
        fb = x + mulq(coef[5*i+1], w1) + mulq(coef[5*i+2], w2);
        if (fourth) fb += mulq(coef[5*i+3], w3) + mulq(coef[5*i+4], w4);
        w0 = sat40(fb);
        case (mode)
          MODE_LOW:  num = w0 + 2*w1 + w2;
          MODE_HIGH: num = w0 - 2*w1 + w2;
          MODE_BAND: num = w0 - 2*w2 + w4;
          default:   num = w0 - mulq(outer_g, w1) + mulq(mid_g, w2) - mulq(outer_g, w3) + w4;
        endcase
        num = sat40(num);
        if (fourth) begin
          dly[4*i+3] = w3;
          dly[4*i+2] = w2;
        end
        dly[4*i+1] = w1;
        dly[4*i]   = w0;
        x = sat40(mulq(coef[5*i], num));
      end
      y = (x + (64'sd1 <<< 19)) >>> 20;
      e.clip = 1'b0;
      if (y > 32767) begin y = 32767; e.clip = 1'b1; end
      else if (y < -32768) begin y = -32768; e.clip = 1'b1; end
      e.smp = y[15:0];
      pending_q.push_back(e);
    endfunction

    function void check_result(logic signed [15:0] smp, logic clip);
      filt_out_t e;
      results++;
      if (clip) clips++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result sample=%0d sat=%0b", smp, clip);
        return;
      end
      e = pending_q.pop_front();
      if (smp !== e.smp || clip !== e.clip) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: sample exp %0d got %0d, sat exp %0b got %0b",
                   results, e.smp, smp, e.clip, clip);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [COEF_W-1:0] cfg_wdata_i = '0;

  bic_in_if  in_ch();
  bic_out_if out_ch();

  butterworth_iir_cascade_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source)
  );

  iir_scoreboard board = new();

  bit gaps_on = 1'b1;  // random idling on both channels
  bit hold_req = 1'b0; // asks the result side for a long hold-off
  int idle_cycles = 0;
  int samples_sent = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_FILTER;
    in_ch.sample_in = '0;
    in_ch.section_index = '0;
    in_ch.coef_select = '0;
    in_ch.coef_value = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      out_ch.ready <= 1'b0;
      for (int i = 0; i < HOLD_LEN; i++) @(posedge clk_i);
    end
    out_ch.ready <= gaps_on ? ($urandom_range(99) >= 19) : 1'b1;
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.sample_out, out_ch.saturated);
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIM) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIM);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item, hold it until the block takes it, then predict.
  task automatic send_item(logic cmd, logic signed [15:0] smp, logic [1:0] sec,
                           logic [2:0] sel, logic signed [COEF_W-1:0] val);
    while (gaps_on && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.sample_in <= smp;
    in_ch.section_index <= sec;
    in_ch.coef_select <= sel;
    in_ch.coef_value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_item(cmd, smp, sec, sel, val);
    if (cmd == CMD_FILTER) samples_sent++;
  endtask

  task automatic filter_sample(logic signed [15:0] smp);
    send_item(CMD_FILTER, smp, '0, '0, '0);
  endtask

  task automatic write_coef(logic [1:0] sec, logic [2:0] sel, logic signed [COEF_W-1:0] val);
    send_item(CMD_COEF, '0, sec, sel, val);
  endtask

  // Stop offering, wait until all results are out, let a coefficient write settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Write one register; the caller drops the write enable after the last one.
  task automatic write_reg(reg_idx_e idx, logic [COEF_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.set_reg(idx, v);
  endtask

  task automatic set_filter(filt_mode_e m, int cnt, logic [COEF_W-1:0] r, logic [COEF_W-1:0] s);
    write_reg(REG_MODE, COEF_W'(m));
    write_reg(REG_COUNT, COEF_W'(cnt));
    write_reg(REG_STOP_OUTER, r);
    write_reg(REG_STOP_MID, s);
    cfg_we_i <= 1'b0;
  endtask

  // Feedback terms small enough to keep most phases out of saturation.
  function automatic logic signed [COEF_W-1:0] tame_coef();
    return $signed(COEF_W'($urandom_range(2**19))) - 24'sd262144;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_gain();
    return $signed(COEF_W'($urandom_range(2**21))) - 24'sd524288;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    if ($urandom_range(3) == 0) return $signed(16'($urandom));
    return $signed(16'($urandom_range(8000))) - 16'sd4000;
  endfunction

  initial begin
    filt_mode_e m;
    int cnt;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: load every coefficient (gain 1.0, light feedback), try the
    // ignored selects, then extreme samples through one low-pass section.
    for (int s = 0; s < N_SEC; s++) begin
      write_coef(2'(s), SEL_GAIN, 24'sd1048576);
      for (int k = 1; k <= SEL_MAX; k++)
        write_coef(2'(s), 3'(k), (k % 2) ? 24'sd131072 : -24'sd65536);
    end
    write_coef(2'd3, 3'd5, 24'sh7FFFFF);
    write_coef(2'd1, 3'd7, 24'sh800000);
    filter_sample(16'sh7FFF);   // full-scale positive
    filter_sample(-16'sh8000);  // full-scale negative
    filter_sample(16'sd0);
    filter_sample(-16'sd1);
    drain();

    // Phases through the register settings; extremes first, then random ones.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: set_filter(MODE_STOP, 4, 24'h7FFFFF, 24'h800000);
        1: set_filter(MODE_BAND, 0, 24'h800000, 24'h7FFFFF);  // no section runs
        2: set_filter(MODE_HIGH, 7, 24'h000000, 24'h000000);  // clamps to all sections
        3: set_filter(MODE_LOW, 1, 24'h100000, 24'h200000);
        default: begin
          m = filt_mode_e'($urandom_range(3));
          cnt = $urandom_range(7);
          set_filter(m, cnt, COEF_W'($urandom), COEF_W'($urandom));
        end
      endcase
      gaps_on = (ph != 5);  // one long stretch with no idling at all
      if (ph == 2) hold_req = 1'b1;  // the block fills up and stalls its input
      for (int it = 0; it < 70; it++) begin
        if ($urandom_range(99) < 85) filter_sample(rand_sample());
        else if ($urandom_range(4) == 0)
          write_coef(2'($urandom), 3'($urandom), $signed(COEF_W'($urandom)));
        else if ($urandom_range(2) == 0)
          write_coef(2'($urandom), SEL_GAIN, rand_gain());
        else
          write_coef(2'($urandom), 3'($urandom_range(1, 4)), tame_coef());
      end
      drain();
    end

    $display("run covered %0d samples, %0d coefficient loads, %0d clipped outputs",
             samples_sent, board.coef_wr, board.clips);
    $display("all four modes, section counts 0 to 7, long result stall and drained pauses");
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.pending_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: butterworth_iir_cascade_unit.f
rtl/bic_pkg.sv
rtl/bic_in_if.sv
rtl/bic_out_if.sv
rtl/bic_cell.sv
rtl/butterworth_iir_cascade_unit.sv
tb/sv/butterworth_iir_cascade_unit_tb.sv
